@@ rtl/chst_pkg.sv @@
// chst_pkg: sizes, mode codes, item types and controller/datapath link
// structs for the chained hash slot table; no dependencies
package chst_pkg;

  localparam int SLOTS    = 256;
  localparam int BUCKETS  = 1024;  // power of two, bucket is the low product bits
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int LINK_W   = SLOT_W + 1;       // one spare code marks an empty link
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int CNT_W    = $clog2(SLOTS + 1);

  localparam logic [31:0] MULT_RESET = 32'd2654435769;
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOTS);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_FLAG   = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         slot_index;
    logic signed [31:0] key_fd;
    logic               active_flag;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] found_slot;
  } out_item_t;

  typedef struct packed {
    logic latch;        // capture the accepted item
    logic mul;          // register key times multiplier
    logic clr_step;     // write one empty bucket head and advance
    logic ins_wr;       // link slot at head of its bucket, record key
    logic walk_init;    // start a chain walk at the bucket head
    logic walk_step;    // advance to the next link
    logic unlink_head;  // bucket head takes the next link
    logic unlink_prev;  // previous link takes the next link
    logic flag_wr;      // write the active flag
    logic res_set;      // store a result
    logic res_hit;
    logic res_found;    // result slot is the current walk position
    logic out_load;     // move the result into the output register
  } chst_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] mode;
    logic       slot_ok;
    logic       walk_end;
    logic       match_remove;
    logic       match_find;
    logic       out_free;
  } chst_status_t;

endpackage

@@ rtl/chst_dp.sv @@
// chst_dp: item registers, hash multiplier, bucket head, link and key memories,
// active flags, chain walk registers and output register; uses chst_pkg
module chst_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chst_pkg::in_item_t    in_item,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata,
  input  chst_pkg::chst_cmd_t   cmd,
  output chst_pkg::chst_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output chst_pkg::out_item_t   out_item
);
  import chst_pkg::*;

  logic [LINK_W-1:0] head_mem   [BUCKETS];
  logic [LINK_W-1:0] link_mem   [SLOTS];
  logic [31:0]       key_mem    [SLOTS];
  logic              active_mem [SLOTS];

  logic [1:0]          mode_r;
  logic [7:0]          slot_r;
  logic [31:0]         key_r;
  logic                flag_r;
  logic [31:0]         mult_r;
  logic [31:0]         prod_r;
  logic [BUCKET_W-1:0] clr_addr_r;
  logic [LINK_W-1:0]   head_q_r;
  logic [LINK_W-1:0]   link_q_r;
  logic [31:0]         key_q_r;
  logic                active_q_r;
  logic [LINK_W-1:0]   cur_r;
  logic [LINK_W-1:0]   prev_r;
  logic [CNT_W-1:0]    n_r;
  logic                res_hit_r;
  logic [7:0]          res_found_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic [SLOT_W-1:0]   slot_a;
  logic [SLOT_W-1:0]   cur_a;
  logic [SLOT_W-1:0]   prev_a;
  logic [BUCKET_W-1:0] bucket;
  logic                head_we;
  logic [BUCKET_W-1:0] head_wa;
  logic [LINK_W-1:0]   head_wd;
  logic                link_we;
  logic [SLOT_W-1:0]   link_wa;
  logic [LINK_W-1:0]   link_wd;

  assign slot_a = SLOT_W'(slot_r);
  assign cur_a  = cur_r[SLOT_W-1:0];
  assign prev_a = prev_r[SLOT_W-1:0];
  // negative descriptors all land in bucket zero
  assign bucket = key_r[31] ? '0 : prod_r[BUCKET_W-1:0];

  always_comb begin
    head_we = 1'b0;
    head_wa = bucket;
    head_wd = NIL_LINK;
    if (cmd.clr_step) begin
      head_we = 1'b1;
      head_wa = clr_addr_r;
    end else if (cmd.ins_wr) begin
      head_we = 1'b1;
      head_wd = LINK_W'(slot_a);
    end else if (cmd.unlink_head) begin
      head_we = 1'b1;
      head_wd = link_q_r;
    end
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = slot_a;
    link_wd = head_q_r;
    if (cmd.ins_wr) begin
      link_we = 1'b1;
    end else if (cmd.unlink_prev) begin
      link_we = 1'b1;
      link_wa = prev_a;
      link_wd = link_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q_r <= head_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q_r <= link_mem[cur_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      key_mem[slot_a] <= key_r;
    end
    key_q_r <= key_mem[cur_a];
  end

  // flags are cleared by the same pass that empties the bucket heads
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      active_mem[clr_addr_r[SLOT_W-1:0]] <= 1'b0;
    end else if (cmd.flag_wr) begin
      active_mem[slot_a] <= flag_r;
    end
    active_q_r <= active_mem[cur_a];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_item.mode;
      slot_r <= in_item.slot_index;
      key_r  <= $unsigned(in_item.key_fd);
      flag_r <= in_item.active_flag;
    end
    if (cmd.mul) begin
      prod_r <= key_r * mult_r;
    end
    if (cmd.walk_init) begin
      cur_r  <= head_q_r;
      prev_r <= NIL_LINK;
      n_r    <= '0;
    end else if (cmd.walk_step) begin
      cur_r  <= link_q_r;
      prev_r <= cur_r;
      n_r    <= n_r + CNT_W'(1);
    end
    if (cmd.res_set) begin
      res_hit_r   <= cmd.res_hit;
      res_found_r <= cmd.res_found ? 8'(cur_a) : 8'd0;
    end
    if (cmd.out_load) begin
      out_item_r.hit        <= res_hit_r;
      out_item_r.found_slot <= res_found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r      <= MULT_RESET;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mult_r <= cfg_wdata;
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + BUCKET_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    status.clr_last     = clr_addr_r == BUCKET_W'(BUCKETS - 1);
    status.mode         = mode_r;
    status.slot_ok      = 32'(slot_r) < 32'(SLOTS);
    status.walk_end     = (cur_r >= NIL_LINK) || (n_r == CNT_W'(SLOTS));
    status.match_remove = 32'(cur_r) == 32'(slot_r);
    status.match_find   = active_q_r && (key_q_r == key_r);
    status.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/chst_ctrl.sv @@
// chst_ctrl: sequencer for the clearing pass, hashing, insert, chain walks and
// result hand-off; uses chst_pkg, drives chst_dp through command/status structs
module chst_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  chst_pkg::chst_status_t status,
  output chst_pkg::chst_cmd_t    cmd
);
  import chst_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MUL, S_HEAD, S_LINK0, S_CHECK, S_EVAL, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   prev_is_nil;
  logic   walk_first_r;

  assign in_ready = state_r == S_IDLE;

  // first link visited has no predecessor
  assign prev_is_nil = walk_first_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (status.mode == MODE_FLAG) begin
          cmd.flag_wr = status.slot_ok;
          cmd.res_set = 1'b1;
          cmd.res_hit = status.slot_ok;
          state_nxt   = S_OUT;
        end else if (status.mode != MODE_FIND && !status.slot_ok) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        // bucket head read is in flight
        state_nxt = S_LINK0;
      end
      S_LINK0: begin
        if (status.mode == MODE_INSERT) begin
          cmd.ins_wr  = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_hit = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        // empty link or walk limit ends in a miss
        if (status.walk_end) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.mode == MODE_REMOVE && status.match_remove) begin
          cmd.unlink_head = 1'b0;
          cmd.unlink_prev = 1'b0;
          cmd.res_set     = 1'b1;
          cmd.res_hit     = 1'b1;
          state_nxt       = S_OUT;
        end else if (status.mode == MODE_FIND && status.match_find) begin
          cmd.res_set   = 1'b1;
          cmd.res_hit   = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.walk_step = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // unlink target depends on whether the match is the chain head
    if (state_r == S_EVAL && status.mode == MODE_REMOVE && status.match_remove) begin
      cmd.unlink_head = prev_is_nil;
      cmd.unlink_prev = !prev_is_nil;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      walk_first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.walk_init) begin
        walk_first_r <= 1'b1;
      end else if (cmd.walk_step) begin
        walk_first_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/chained_hash_slot_table.sv @@
// Chained hash slot table: one item at a time, result held in an output register.
// Flag items skip the chains; insert links the slot after the bucket head read;
// remove/find walk the chain, each link costing a registered link/key memory read.
// out_valid rises when the result is loaded, later while an earlier result still
// waits. After rst_n the bucket heads and active flags are cleared with in_ready
// low; cfg writes are taken throughout.
module chained_hash_slot_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  chst_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output chst_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import chst_pkg::*;

  chst_cmd_t    cmd;
  chst_status_t status;

  chst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  chst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ rtl/chst_checker.sv @@
// chst_checker: port-level assertions for chained_hash_slot_table and the bind
// that attaches them; uses chst_pkg
module chst_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input chst_pkg::out_item_t out_item
);

  // clearing pass keeps input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("in_ready high during clearing pass");

  // one item in flight: input closes after each transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open right after a transfer");

  // a new result only appears at the end of item processing
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  // a miss never names a slot
  a_miss_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |-> (out_item.found_slot == 8'd0))
    else $error("miss with nonzero slot");

endmodule

bind chained_hash_slot_table chst_checker u_chst_checker (.*);

@@ bench/slot_table_check_pkg.sv @@
// slot_table_check_pkg: result tracker for the chained hash slot table bench,
// holding its own copy of bucket heads, links, keys and active flags
// depends on chst_pkg for sizes, mode codes and item types
package slot_table_check_pkg;
  import chst_pkg::*;

  class slot_table_tracker;
    int unsigned       failures;
    logic [31:0]       multiplier;
    logic [LINK_W-1:0] heads [BUCKETS];
    logic [LINK_W-1:0] links [SLOTS];
    logic [31:0]       keys [SLOTS];
    bit                active [SLOTS];
    out_item_t         expected_answers [$];

    function new();
      failures = 0;
      multiplier = MULT_RESET;
      foreach (heads[b]) heads[b] = NIL_LINK;
      foreach (links[s]) begin
        links[s] = '0;
        keys[s] = '0;
        active[s] = 1'b0;
      end
    endfunction

    function void set_multiplier(logic [31:0] value);
      multiplier = value;
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    function logic [BUCKET_W-1:0] bucket_of_key(logic [31:0] key);
      logic [31:0] prod;
      prod = key * multiplier;
      // negative descriptors all land in the first bucket
      if (key[31]) return '0;
      return prod[BUCKET_W-1:0];
    endfunction

    // applies one request to the tables and returns the answer it produces
    function out_item_t answer_for(in_item_t it);
      out_item_t         res;
      logic [BUCKET_W-1:0] b;
      logic [LINK_W-1:0] cur;
      logic [LINK_W-1:0] prev;
      logic [31:0]       key;
      int                s;
      int                n;
      res = '0;
      key = it.key_fd;
      b = bucket_of_key(key);
      s = it.slot_index;
      if (s >= SLOTS && it.mode != MODE_FIND) return res;
      case (it.mode)
        MODE_INSERT: begin
          links[s] = heads[b];
          heads[b] = LINK_W'(s);
          keys[s] = key;
          res.hit = 1'b1;
        end
        MODE_REMOVE: begin
          prev = NIL_LINK;
          cur = heads[b];
          for (n = 0; n < SLOTS && cur < NIL_LINK; n++) begin
            if (cur == s) begin
              if (prev == NIL_LINK) heads[b] = links[cur];
              else links[prev] = links[cur];
              res.hit = 1'b1;
              break;
            end
            prev = cur;
            cur = links[cur];
          end
        end
        MODE_FIND: begin
          cur = heads[b];
          // walk is bounded so a looped chain ends in a miss
          for (n = 0; n < SLOTS && cur < NIL_LINK; n++) begin
            if (active[cur] && keys[cur] == key) begin
              res.hit = 1'b1;
              res.found_slot = cur[7:0];
              break;
            end
            cur = links[cur];
          end
        end
        default: begin
          active[s] = it.active_flag;
          res.hit = 1'b1;
        end
      endcase
      return res;
    endfunction

    function void note_request(in_item_t it);
      expected_answers.push_back(answer_for(it));
    endfunction

    function void check_answer(out_item_t got);
      out_item_t want;
      if (expected_answers.size() == 0) begin
        $error("result with nothing outstanding: hit %0d found_slot %0d",
               got.hit, got.found_slot);
        failures++;
        return;
      end
      want = expected_answers.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
        failures++;
      end
      if (got.found_slot !== want.found_slot) begin
        $error("found_slot: expected %0d, actual %0d", want.found_slot, got.found_slot);
        failures++;
      end
    endfunction
  endclass

endpackage

@@ bench/chained_hash_slot_table_test.sv @@
// chained_hash_slot_table_test: drives insert/remove/find/flag requests into the
// slot table under several multipliers and idling styles, checks every answer
// depends on chst_pkg, slot_table_check_pkg and the chained_hash_slot_table rtl
module chained_hash_slot_table_test;
  import chst_pkg::*;
  import slot_table_check_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 600;
  localparam int STALL_LIMIT   = 20000;
  localparam int POOL_KEYS     = 32;
  localparam int MAX_LINKED    = 40;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  slot_table_tracker tracker;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // which slots the stimulus believes are chained, and under which key
  bit          slot_linked [SLOTS];
  logic [31:0] slot_tag_key [SLOTS];
  int          linked_count = 0;
  logic [31:0] key_pool [POOL_KEYS];

  chained_hash_slot_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_answer(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer_request(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(it);
  endtask

  task automatic offer_fields(logic [1:0] mode, int slot, logic [31:0] key, logic flag);
    in_item_t it;
    it.mode = mode;
    it.slot_index = 8'(slot);
    it.key_fd = key;
    it.active_flag = flag;
    offer_request(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_multiplier(logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_multiplier(value);
  endtask

  // unlink everything the stimulus chained before the hash changes
  task automatic remove_linked();
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_linked[s]) begin
        offer_fields(MODE_REMOVE, s, slot_tag_key[s], 1'b0);
        slot_linked[s] = 1'b0;
      end
    end
    linked_count = 0;
  endtask

  task automatic set_idling(idle_style_t style);
    case (style)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 49;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct <= 49;
      end
      default: begin
        send_idle_pct = 37;
        recv_stall_pct <= 37;
      end
    endcase
  endtask

  function automatic void refill_keys();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int k = 4; k < POOL_KEYS; k++) begin
      case ($urandom_range(3))
        0: key_pool[k] = $urandom;
        1: key_pool[k] = 32'd0 - $urandom_range(1, 64);
        default: key_pool[k] = $urandom_range(1, 4095);
      endcase
    end
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    int       s;
    int       pick;
    int       pick2;
    it.mode = MODE_FIND;
    it.slot_index = 8'($urandom_range(SLOTS - 1));
    it.key_fd = key_pool[$urandom_range(POOL_KEYS - 1)];
    it.active_flag = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 12) begin
      // noise: any mode on any slot, double insertion included
      it.mode = 2'($urandom_range(3));
      if ($urandom_range(1)) it.key_fd = $urandom;
      if (it.mode == MODE_INSERT) begin
        s = it.slot_index;
        if (!slot_linked[s]) linked_count++;
        slot_linked[s] = 1'b1;
        slot_tag_key[s] = it.key_fd;
      end
      return it;
    end
    if (linked_count < 6 || (linked_count < MAX_LINKED && pick < 40)) begin
      do s = $urandom_range(SLOTS - 1); while (slot_linked[s]);
      it.mode = MODE_INSERT;
      it.slot_index = 8'(s);
      slot_linked[s] = 1'b1;
      slot_tag_key[s] = it.key_fd;
      linked_count++;
      return it;
    end
    do s = $urandom_range(SLOTS - 1); while (!slot_linked[s]);
    it.slot_index = 8'(s);
    pick2 = $urandom_range(99);
    if (pick2 < 30) begin
      it.mode = MODE_FLAG;
      it.active_flag = ($urandom_range(3) != 0);
    end else if (pick2 < 60) begin
      it.mode = MODE_FIND;
      it.key_fd = slot_tag_key[s];
    end else if (pick2 < 75) begin
      it.mode = MODE_FIND;
    end else begin
      it.mode = MODE_REMOVE;
      it.key_fd = slot_tag_key[s];
      slot_linked[s] = 1'b0;
      linked_count--;
    end
    return it;
  endfunction

  task automatic run_directed();
    offer_fields(MODE_FIND,   0,   32'h0000_0000, 1'b0);  // empty table
    offer_fields(MODE_INSERT, 0,   32'h7FFF_FFFF, 1'b0);
    offer_fields(MODE_FIND,   0,   32'h7FFF_FFFF, 1'b0);  // chained but not active
    offer_fields(MODE_FLAG,   0,   32'h0000_0000, 1'b1);
    offer_fields(MODE_FIND,   0,   32'h7FFF_FFFF, 1'b0);
    offer_fields(MODE_INSERT, 255, 32'h8000_0000, 1'b0);
    offer_fields(MODE_FLAG,   255, 32'h0000_0000, 1'b1);
    offer_fields(MODE_INSERT, 170, 32'hFFFF_FFFF, 1'b0);
    offer_fields(MODE_FLAG,   170, 32'h0000_0000, 1'b1);
    offer_fields(MODE_FIND,   7,   32'hFFFF_FFFF, 1'b0);
    offer_fields(MODE_FIND,   7,   32'h8000_0000, 1'b0);  // one link down
    offer_fields(MODE_INSERT, 85,  32'h8000_0000, 1'b0);  // same key twice
    offer_fields(MODE_FLAG,   85,  32'h0000_0000, 1'b1);
    offer_fields(MODE_FIND,   0,   32'h8000_0000, 1'b0);
    offer_fields(MODE_FLAG,   85,  32'h0000_0000, 1'b0);
    offer_fields(MODE_FIND,   0,   32'h8000_0000, 1'b0);  // skips inactive head
    offer_fields(MODE_REMOVE, 170, 32'hFFFF_FFFF, 1'b0);  // unlink mid chain
    offer_fields(MODE_REMOVE, 170, 32'hFFFF_FFFF, 1'b0);  // already gone
    offer_fields(MODE_REMOVE, 85,  32'h8000_0000, 1'b0);  // unlink at head
    offer_fields(MODE_INSERT, 255, 32'h8000_0000, 1'b0);  // re-insert makes a self loop
    offer_fields(MODE_FIND,   0,   32'hFFFF_FFFF, 1'b0);  // walk runs out on the loop
    offer_fields(MODE_INSERT, 255, 32'h0000_0001, 1'b0);  // moves slot, loop broken
    offer_fields(MODE_REMOVE, 255, 32'hFFFF_FFFB, 1'b0);
    offer_fields(MODE_REMOVE, 255, 32'h0000_0001, 1'b0);
    offer_fields(MODE_REMOVE, 0,   32'h7FFF_FFFF, 1'b0);
  endtask

  initial begin
    logic [31:0] mults [PHASES];
    tracker = new();
    mults[0] = MULT_RESET;
    mults[1] = 32'h0000_0000;
    mults[2] = 32'hFFFF_FFFF;
    mults[3] = 32'h0000_0001;
    mults[4] = $urandom | 32'd1;
    mults[5] = $urandom;
    mults[6] = MULT_RESET;
    mults[7] = $urandom | 32'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      // phase zero keeps the multiplier that reset left
      if (p != 0) begin
        remove_linked();
        wait_idle();
        write_multiplier(mults[p]);
      end
      refill_keys();
      set_idling(idle_style_t'(p % 4));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          if (p % 2 == 1) hold_toggle <= ~hold_toggle;
          else wait_idle();
        end
        offer_request(random_request());
      end
    end
    remove_linked();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/chst_pkg.sv
rtl/chst_dp.sv
rtl/chst_ctrl.sv
rtl/chained_hash_slot_table.sv
rtl/chst_checker.sv
bench/slot_table_check_pkg.sv
bench/chained_hash_slot_table_test.sv
